[rtl/imm_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helpers for the integer matrix multiplier.
package imm_pkg;

  localparam int unsigned MAX_DIM   = 8;
  localparam int unsigned IDX_W     = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W    = 2 * IDX_W;
  localparam int unsigned DEPTH     = MAX_DIM * MAX_DIM;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIM_W     = 4;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned FIELD_W   = 2 * IDX_W + DATA_W;
  localparam int unsigned TDATA_W   = ((FIELD_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  // Controller to datapath commands.
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
    logic             first_k;
    logic             last_k;
    logic             elem_last;
  } imm_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_busy;
    logic done;
  } imm_sts_t;

  // Zero counts as one, anything above MAX_DIM as MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/imm_ctrl.sv]
`timescale 1ns / 1ps
// Controller: config registers, item decode and the i/j/k walk of a compute.
module imm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [imm_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic [imm_pkg::OP_W-1:0]      in_op_i,
  output logic                          in_ready_o,
  input  imm_pkg::imm_sts_t             sts_i,
  output imm_pkg::imm_cmd_t             cmd_o
);
  import imm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_ISSUE = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [DIM_W-1:0] rows_q, inner_q, cols_q;
  logic [DIM_W-1:0] nr_q, nr_d, nk_q, nk_d, nc_q, nc_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic             accept, last_k, last_i, last_j;

  assign accept = in_valid_i && in_ready_o;
  assign last_k = ({1'b0, k_q} == nk_q - DIM_W'(1));
  assign last_i = ({1'b0, i_q} == nr_q - DIM_W'(1));
  assign last_j = ({1'b0, j_q} == nc_q - DIM_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_RESET;
      inner_q <= DIM_RESET;
      cols_q  <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROWS_A:    rows_q  <= cfg_data_i;
        REG_INNER_DIM: inner_q <= cfg_data_i;
        REG_COLS_B:    cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    nr_d    = nr_q;
    nk_d    = nk_q;
    nc_d    = nc_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_op_i == OP_COMPUTE) begin
          nr_d    = clamp_dim(rows_q);
          nk_d    = clamp_dim(inner_q);
          nc_d    = clamp_dim(cols_q);
          i_d     = '0;
          j_d     = '0;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (!sts_i.out_busy) begin
          k_d     = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (last_k) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (sts_i.done) begin
          if (last_i && last_j) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_START;
            if (last_j) begin
              j_d = '0;
              i_d = i_q + IDX_W'(1);
            end else begin
              j_d = j_q + IDX_W'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nr_q <= nr_d;
    nk_q <= nk_d;
    nc_q <= nc_d;
    i_q  <= i_d;
    j_q  <= j_d;
    k_q  <= k_d;
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o.wr_a      = accept && (in_op_i == OP_LOAD_A);
    cmd_o.wr_b      = accept && (in_op_i == OP_LOAD_B);
    cmd_o.issue     = (state_q == ST_ISSUE);
    cmd_o.row       = i_q;
    cmd_o.col       = j_q;
    cmd_o.k         = k_q;
    cmd_o.first_k   = (k_q == '0);
    cmd_o.last_k    = last_k;
    cmd_o.elem_last = last_i && last_j;
  end

  a_no_issue_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !cmd_o.issue)
    else $error("read issued while idle");

  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op_i == OP_COMPUTE) |=> (state_q == ST_START))
    else $error("compute item did not start a run");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !(cmd_o.wr_a || cmd_o.wr_b))
    else $error("store written during a compute");

endmodule

[rtl/imm_datapath.sv]
`timescale 1ns / 1ps
// Datapath: A and B stores, multiply stage, accumulator and result register.
module imm_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  imm_pkg::imm_cmd_t          cmd_i,
  output imm_pkg::imm_sts_t          sts_o,
  input  logic [imm_pkg::IDX_W-1:0]  ld_row_i,
  input  logic [imm_pkg::IDX_W-1:0]  ld_col_i,
  input  logic [imm_pkg::DATA_W-1:0] ld_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [imm_pkg::IDX_W-1:0]  out_row_o,
  output logic [imm_pkg::IDX_W-1:0]  out_col_o,
  output logic [imm_pkg::DATA_W-1:0] out_sum_o,
  output logic                       out_last_o
);
  import imm_pkg::*;

  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];

  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [DATA_W-1:0] rd_a_q, rd_b_q, prod_q, acc_q, acc_next;
  logic              v1_q, f1_q, l1_q, v2_q, f2_q, l2_q;
  logic              out_valid_q, done;
  logic [IDX_W-1:0]  out_row_q, out_col_q;
  logic [DATA_W-1:0] out_sum_q;
  logic              out_last_q;

  assign wr_addr   = {ld_row_i, ld_col_i};
  assign rd_addr_a = {cmd_i.row, cmd_i.k};
  assign rd_addr_b = {cmd_i.k, cmd_i.col};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      mem_a[wr_addr] <= ld_value_i;
    end
    rd_a_q <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_b) begin
      mem_b[wr_addr] <= ld_value_i;
    end
    rd_b_q <= mem_b[rd_addr_b];
  end

  // stage tags: 1 = read data, 2 = product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q   <= cmd_i.first_k;
    l1_q   <= cmd_i.last_k;
    f2_q   <= f1_q;
    l2_q   <= l1_q;
    prod_q <= DATA_W'(rd_a_q * rd_b_q);
  end

  assign acc_next = (f2_q ? '0 : acc_q) + prod_q;
  assign done     = v2_q && l2_q;

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_q <= acc_next;
    end
    if (done) begin
      out_sum_q  <= acc_next;
      out_row_q  <= cmd_i.row;
      out_col_q  <= cmd_i.col;
      out_last_q <= cmd_i.elem_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_busy = out_valid_q;
  assign sts_o.done     = done;
  assign out_valid_o    = out_valid_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign out_sum_o      = out_sum_q;
  assign out_last_o     = out_last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !out_valid_q)
    else $error("result landed on a full output register");

endmodule

[rtl/integer_matrix_multiply.sv]
`timescale 1ns / 1ps
// Top level of the integer matrix multiplier C = A x B.
//
//  channel  dir  handshake                       payload
//  s_axis   in   s_axis_tvalid / s_axis_tready   tuser: operation; tdata: row, col, value
//  m_axis   out  m_axis_tvalid / m_axis_tready   tdata: row, col, sum; tlast: last
//  cfg      in   cfg_we_i (no wait)              cfg_idx_i, cfg_data_i
//
// Load items are written as they are accepted; the input is ready whenever no compute runs.
// A compute walks i, j, k over one multiplier, dimensions clamped to 1..8: each
// element is a start, inner_dim reads, multiply and accumulate, then the output
// handoff; the next element's reads wait for that handoff. A stalled m_axis
// holds the next element; the final result may wait while new items are
// accepted. Reset restores all dimensions to 8; stores start undefined.
module integer_matrix_multiply (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [imm_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [39:0] row_index[2:0], col_index[5:3], element_value[37:6], zero pad
  input  logic [imm_pkg::TDATA_W-1:0]   s_axis_tdata,
  // [1:0] operation
  input  logic [imm_pkg::OP_W-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [39:0] out_row[2:0], out_col[5:3], sum_value[37:6], zero pad
  output logic [imm_pkg::TDATA_W-1:0]   m_axis_tdata,
  output logic                          m_axis_tlast
);
  import imm_pkg::*;

  imm_cmd_t          cmd;
  imm_sts_t          sts;
  logic [IDX_W-1:0]  out_row, out_col;
  logic [DATA_W-1:0] out_sum;

  imm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  imm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .ld_row_i    (s_axis_tdata[IDX_W-1:0]),
    .ld_col_i    (s_axis_tdata[2*IDX_W-1:IDX_W]),
    .ld_value_i  (s_axis_tdata[FIELD_W-1:2*IDX_W]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_sum_o   (out_sum),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = TDATA_W'({out_sum, out_col, out_row});

endmodule

[tb/sv/integer_matrix_multiply_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the integer matrix multiplier: loads, computes, backpressure.
module integer_matrix_multiply_tb;
  import imm_pkg::*;

  // Reserved operation code: the block drops such items without a result.
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam int unsigned RANDOM_ITEMS  = 80;
  localparam int unsigned SETTLE_CYCLES = 8;   // time for the last load to land
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned HOLD_CYCLES   = 300; // one long output stall
  localparam int unsigned REPORT_LIMIT  = 10;

  // One result element as it leaves the block.
  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] sum;
    logic              last;
  } product_elem_t;

  // Mirrors both element stores and the dimension registers. Loads update the
  // mirror, a compute item queues every product element it should produce.
  class product_tracker;
    logic [DATA_W-1:0] mat_a [DEPTH];
    logic [DATA_W-1:0] mat_b [DEPTH];
    bit                a_set [DEPTH];
    bit                b_set [DEPTH];
    int unsigned       n_rows  = MAX_DIM;
    int unsigned       n_inner = MAX_DIM;
    int unsigned       n_cols  = MAX_DIM;
    product_elem_t     pending_products [$];
    int unsigned       errors;

    function void set_dim(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      int unsigned d;
      // zero reads as one, anything past the store size as the store size
      d = (value == 0) ? 1 : ((value > MAX_DIM) ? MAX_DIM : value);
      case (idx)
        REG_ROWS_A:    n_rows  = d;
        REG_INNER_DIM: n_inner = d;
        REG_COLS_B:    n_cols  = d;
        default: ;
      endcase
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                            logic [IDX_W-1:0] col, logic [DATA_W-1:0] val);
      int unsigned   addr;
      logic [DATA_W-1:0] acc;
      product_elem_t e;
      addr = row * MAX_DIM + col;
      case (op)
        OP_LOAD_A: begin
          mat_a[addr] = val;
          a_set[addr] = 1'b1;
        end
        OP_LOAD_B: begin
          mat_b[addr] = val;
          b_set[addr] = 1'b1;
        end
        OP_COMPUTE: begin
          for (int i = 0; i < n_rows; i++) begin
            for (int j = 0; j < n_cols; j++) begin
              acc = '0;
              // 32-bit context: products and sums wrap like C int
              for (int k = 0; k < n_inner; k++) begin
                acc = acc + mat_a[i * MAX_DIM + k] * mat_b[k * MAX_DIM + j];
              end
              e.row  = IDX_W'(i);
              e.col  = IDX_W'(j);
              e.sum  = acc;
              e.last = (i == n_rows - 1) && (j == n_cols - 1);
              pending_products.push_back(e);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // True when a compute would read only entries that were loaded.
    function bit operands_ready();
      for (int k = 0; k < n_inner; k++) begin
        for (int i = 0; i < n_rows; i++) begin
          if (!a_set[i * MAX_DIM + k]) return 1'b0;
        end
        for (int j = 0; j < n_cols; j++) begin
          if (!b_set[k * MAX_DIM + j]) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // First entry a compute needs that was never loaded.
    function bit find_missing(output logic [OP_W-1:0] op, output logic [IDX_W-1:0] row,
                              output logic [IDX_W-1:0] col);
      op  = OP_LOAD_A;
      row = '0;
      col = '0;
      for (int k = 0; k < n_inner; k++) begin
        for (int i = 0; i < n_rows; i++) begin
          if (!a_set[i * MAX_DIM + k]) begin
            op  = OP_LOAD_A;
            row = IDX_W'(i);
            col = IDX_W'(k);
            return 1'b1;
          end
        end
        for (int j = 0; j < n_cols; j++) begin
          if (!b_set[k * MAX_DIM + j]) begin
            op  = OP_LOAD_B;
            row = IDX_W'(k);
            col = IDX_W'(j);
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void check_elem(product_elem_t got);
      product_elem_t want;
      if (pending_products.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("unexpected result: row %0d col %0d sum %0d last %0b",
                   got.row, got.col, $signed(got.sum), got.last);
        end
        return;
      end
      want = pending_products.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("mismatch: expected row %0d col %0d sum %0d last %0b,",
                   want.row, want.col, $signed(want.sum), want.last,
                   " got row %0d col %0d sum %0d last %0b",
                   got.row, got.col, $signed(got.sum), got.last);
        end
      end
    endfunction
  endclass

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx    = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 s_tvalid   = 1'b0;
  logic [TDATA_W-1:0]   s_tdata    = '0;
  logic [OP_W-1:0]      s_tuser    = '0;
  logic                 m_tready   = 1'b0;
  logic                 s_axis_tready;
  logic                 m_axis_tvalid;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tlast;

  bit quiet     = 1'b0; // no random gaps on either side during this phase
  bit in_random = 1'b0;
  bit held_off  = 1'b0;

  product_tracker sb;

  integer_matrix_multiply dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Register values: mostly small sizes, a few full size or out of range.
  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return CFG_W'($urandom_range(MAX_DIM + 1, 15));
    if (r < 4) return CFG_W'(MAX_DIM);
    return CFG_W'($urandom_range(1, 4));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return DATA_W'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // Back-to-back register writes; the tracker follows each one at its edge.
  task automatic write_dims(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] c);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_ROWS_A;
    cfg_data <= r;
    @(posedge clk_i);
    sb.set_dim(REG_ROWS_A, r);
    cfg_idx  <= REG_INNER_DIM;
    cfg_data <= k;
    @(posedge clk_i);
    sb.set_dim(REG_INNER_DIM, k);
    cfg_idx  <= REG_COLS_B;
    cfg_data <= c;
    @(posedge clk_i);
    sb.set_dim(REG_COLS_B, c);
    cfg_we   <= 1'b0;
  endtask

  // Offer one item, wait for the handshake, then maybe pause.
  task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                           logic [IDX_W-1:0] col, logic [DATA_W-1:0] val);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= TDATA_W'({val, col, row});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, row, col, val);
    if (!quiet) begin
      gap = pick_gap();
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Block is idle once every product came out and a load would have landed.
  task automatic settle();
    while (sb.pending_products.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result side: random stalls, plus one long hold-off while the sender keeps
  // pushing, so the block backs up all the way to its input.
  initial begin
    int unsigned gap;
    int unsigned hold;
    gap  = 0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_tready) begin
        sb.check_elem({m_axis_tdata[IDX_W-1:0], m_axis_tdata[2*IDX_W-1:IDX_W],
                       m_axis_tdata[2*IDX_W+DATA_W-1:2*IDX_W], m_axis_tlast});
        if (!quiet) gap = pick_gap();
      end
      if (!held_off && in_random && m_axis_tvalid && s_tvalid) begin
        held_off = 1'b1;
        hold     = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    int unsigned       n_items;
    int unsigned       len;
    int unsigned       pick;
    bit                wellformed;

    sb = new;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 1x1x1 via zero registers, wrap of the largest values, a
    // reserved operation, loads outside the configured size.
    write_dims('0, '0, '0);
    send_item(OP_LOAD_A, 3'd0, 3'd0, 32'h7fff_ffff);
    send_item(OP_LOAD_B, 3'd0, 3'd0, 32'h7fff_ffff);
    send_item(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
    send_item(OP_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
    send_item(OP_LOAD_B, 3'd0, 3'd0, 32'hffff_ffff);
    send_item(OP_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff); // index and value unused
    send_item(OP_NONE, 3'd7, 3'd7, 32'hffff_ffff);
    send_item(OP_LOAD_A, 3'd7, 3'd7, 32'h1234_5678);
    send_item(OP_LOAD_B, 3'd7, 3'd7, 32'hedcb_a987);
    send_item(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
    s_tvalid <= 1'b0;
    settle();

    // Directed: registers above the store size clamp to 8, giving the full
    // 8x8 result of an outer product.
    write_dims(4'd15, 4'd1, 4'd9);
    while (sb.find_missing(op, row, col)) send_item(op, row, col, pick_value());
    send_item(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
    s_tvalid <= 1'b0;
    settle();

    // Random phases. Most are load runs closed by a compute; the rest mix
    // operations freely. A compute that would read an unloaded entry is
    // turned into the load of that entry.
    in_random = 1'b1;
    n_items   = 0;
    while (n_items < RANDOM_ITEMS) begin
      write_dims(pick_dim(), pick_dim(), pick_dim());
      quiet      = ($urandom_range(0, 4) == 0);
      wellformed = ($urandom_range(0, 4) != 0);
      len        = $urandom_range(4, 16);
      for (int n = 0; n < len; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          op = OP_NONE;
        end else if (pick < 24 || (wellformed && n == len - 1)) begin
          op = OP_COMPUTE;
        end else begin
          op = $urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A;
        end
        row = IDX_W'($urandom_range(0, 7));
        col = IDX_W'($urandom_range(0, 7));
        if (op == OP_COMPUTE && !sb.operands_ready()) begin
          void'(sb.find_missing(op, row, col));
        end else if ((op == OP_LOAD_A || op == OP_LOAD_B) && wellformed &&
                     !sb.operands_ready() && $urandom_range(0, 1)) begin
          void'(sb.find_missing(op, row, col));
        end else if (op == OP_LOAD_A && $urandom_range(0, 9) < 7) begin
          // keep most loads inside the active part of the stores
          row = IDX_W'($urandom_range(0, sb.n_rows - 1));
          col = IDX_W'($urandom_range(0, sb.n_inner - 1));
        end else if (op == OP_LOAD_B && $urandom_range(0, 9) < 7) begin
          row = IDX_W'($urandom_range(0, sb.n_inner - 1));
          col = IDX_W'($urandom_range(0, sb.n_cols - 1));
        end
        send_item(op, row, col, pick_value());
        if (op != OP_NONE) n_items++;
      end
      s_tvalid <= 1'b0;
      settle();
    end
    in_random = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_products.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
